// ===== hw/rtl/lav_pkg.sv =====
package lav_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CW     = FRAC_BITS + 2;
    localparam int PRW    = CW + 32;
    localparam int VW     = PRW + 1;
    localparam int DW     = PRW + 2;
    localparam int MW     = 30;
    localparam int TOPB   = MW - 1;
    localparam int PW     = $clog2(VW);
    localparam int NCH    = (VW + 15) / 16;
    localparam int SQ_IT  = 4;
    localparam int SQ_ST  = 32 / SQ_IT;
    localparam int QB     = FRAC_BITS + 1;
    localparam int DV_IT  = 4;
    localparam int DV_ST  = (QB + DV_IT - 1) / DV_IT;
    localparam int QBP    = DV_ST * DV_IT;
    localparam int NW     = MW + FRAC_BITS;
    localparam int RW     = 33;
    localparam int NRM_ST = 6 + SQ_ST + DV_ST + 1;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q eye_x;
        t_q eye_y;
        t_q eye_z;
        t_q target_x;
        t_q target_y;
        t_q target_z;
        t_q upvec_x;
        t_q upvec_y;
        t_q upvec_z;
    } t_in_req;

    typedef struct packed {
        logic [1:0] row_index;
        t_q         elem0;
        t_q         elem1;
        t_q         elem2;
        t_q         elem3;
        logic       last_row;
        logic       degenerate;
    } t_out_req;

    typedef logic [2:0][CW-1:0] t_uvec;
    typedef logic [2:0][VW-1:0] t_wvec;
    typedef logic [2:0][31:0]   t_evec;

    typedef struct packed {
        t_evec eye;
        t_evec up;
        t_uvec n;
        t_uvec u;
        logic  ok;
    } t_side;

    typedef struct packed {
        t_uvec u;
        t_uvec v;
        t_uvec n;
        t_evec tr;
        logic  ok;
    } t_mat;

endpackage

// ===== hw/rtl/lav_norm.sv =====
module lav_norm import lav_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_wvec i_vec,
    input  t_side i_side,
    output logic  o_valid,
    output t_uvec o_vec,
    output logic  o_ok,
    output t_side o_side
);

    typedef struct packed {
        logic [2:0]          neg;
        logic                zero;
        logic [2:0][MW-1:0]  m;
    } t_nc;

    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] root;
        logic [63:0] op;
    } t_sq;

    typedef struct packed {
        logic [2:0][RW-1:0]  rem;
        logic [2:0][QBP-1:0] q;
        logic [2:0][QBP-1:0] op;
        logic [31:0]         len;
    } t_dv;

    function automatic t_sq sq_step(input t_sq x);
        t_sq         y;
        logic [35:0] tr;
        y = x;
        for (int j = 0; j < SQ_IT; j++) begin
            y.rem = {y.rem[33:0], y.op[63:62]};
            y.op  = {y.op[61:0], 2'b00};
            tr    = {2'b00, y.root, 2'b01};
            if (y.rem >= tr) begin
                y.rem  = y.rem - tr;
                y.root = {y.root[30:0], 1'b1};
            end else begin
                y.root = {y.root[30:0], 1'b0};
            end
        end
        return y;
    endfunction

    function automatic t_dv dv_step(input t_dv x);
        t_dv y;
        y = x;
        for (int j = 0; j < DV_IT; j++) begin
            for (int i = 0; i < 3; i++) begin
                y.rem[i] = {y.rem[i][RW-2:0], y.op[i][QBP-1]};
                y.op[i]  = {y.op[i][QBP-2:0], 1'b0};
                if (y.rem[i] >= {1'b0, y.len}) begin
                    y.rem[i] = y.rem[i] - {1'b0, y.len};
                    y.q[i]   = {y.q[i][QBP-2:0], 1'b1};
                end else begin
                    y.q[i]   = {y.q[i][QBP-2:0], 1'b0};
                end
            end
        end
        return y;
    endfunction

    logic  r_v  [NRM_ST];
    t_side r_sd [NRM_ST];

    logic [2:0]          r1_neg;
    logic [2:0][VW-1:0]  r1_m;
    logic [2:0]          r2_neg;
    logic [2:0][VW-1:0]  r2_m;
    logic [NCH-1:0]      r2_nz;
    logic [3:0]          r2_pos [NCH];
    logic [2:0]          r3_neg;
    logic [2:0][VW-1:0]  r3_m;
    logic [PW-1:0]       r3_rsh;
    logic [PW-1:0]       r3_lsh;
    logic                r3_zero;
    t_nc                 r4_c;
    logic [2:0][2*MW-1:0] r5_sq;
    t_nc                 r5_c;
    logic [2*MW+1:0]     r6_sum;
    t_nc                 r6_c;
    t_sq                 r_sq [SQ_ST];
    t_nc                 r_sc [SQ_ST];
    t_dv                 r_dv [DV_ST];
    t_nc                 r_dc [DV_ST];
    t_uvec               r_ov;
    logic                r_ook;

    logic [NCH*16-1:0]   w_or;
    logic [3:0]          w_pos [NCH];
    logic [PW-1:0]       w_p;
    t_sq                 w_sq0;
    t_dv                 w_dv0;
    logic [NW-1:0]       w_num [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NRM_ST; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NRM_ST; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int k = 1; k < NRM_ST; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    // magnitude and sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= i_vec[i][VW-1];
                r1_m[i]   <= i_vec[i][VW-1] ? (~i_vec[i] + VW'(1)) : i_vec[i];
            end
        end
    end

    // leading one, per 16-bit chunk
    assign w_or = (NCH*16)'(r1_m[0] | r1_m[1] | r1_m[2]);

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_pos[c] = 4'd0;
            for (int j = 0; j < 16; j++) begin
                if (w_or[c*16 + j]) w_pos[c] = 4'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_neg <= r1_neg;
            r2_m   <= r1_m;
            for (int c = 0; c < NCH; c++) begin
                r2_nz[c]  <= |w_or[c*16 +: 16];
                r2_pos[c] <= w_pos[c];
            end
        end
    end

    always_comb begin
        w_p = '0;
        for (int c = 0; c < NCH; c++) begin
            if (r2_nz[c]) w_p = PW'(c * 16) + PW'(r2_pos[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_neg  <= r2_neg;
            r3_m    <= r2_m;
            r3_zero <= ~|r2_nz;
            r3_rsh  <= (w_p > PW'(TOPB)) ? w_p - PW'(TOPB) : '0;
            r3_lsh  <= (w_p < PW'(TOPB)) ? PW'(TOPB) - w_p : '0;
        end
    end

    // scale so the largest magnitude has its top bit at TOPB
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_c.neg  <= r3_neg;
            r4_c.zero <= r3_zero;
            for (int i = 0; i < 3; i++) begin
                r4_c.m[i] <= MW'((r3_m[i] >> r3_rsh) << r3_lsh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_c <= r4_c;
            for (int i = 0; i < 3; i++) r5_sq[i] <= r4_c.m[i] * r4_c.m[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_c   <= r5_c;
            r6_sum <= (2*MW+2)'(r5_sq[0]) + (2*MW+2)'(r5_sq[1]) + (2*MW+2)'(r5_sq[2]);
        end
    end

    // square root, SQ_IT result bits per stage
    always_comb begin
        w_sq0.rem  = '0;
        w_sq0.root = '0;
        w_sq0.op   = 64'(r6_sum);
    end

    for (genvar s = 0; s < SQ_ST; s++) begin : g_sq
        if (s == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq[s] <= sq_step(w_sq0);
                    r_sc[s] <= r6_c;
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq[s] <= sq_step(r_sq[s-1]);
                    r_sc[s] <= r_sc[s-1];
                end
            end
        end
    end

    // divide each magnitude by the length, DV_IT quotient bits per stage
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i]     = {r_sc[SQ_ST-1].m[i], {FRAC_BITS{1'b0}}};
            w_dv0.rem[i] = RW'(w_num[i] >> QBP);
            w_dv0.op[i]  = w_num[i][QBP-1:0];
            w_dv0.q[i]   = '0;
        end
        w_dv0.len = r_sq[SQ_ST-1].root;
    end

    for (genvar s = 0; s < DV_ST; s++) begin : g_dv
        if (s == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv[s] <= dv_step(w_dv0);
                    r_dc[s] <= r_sc[SQ_ST-1];
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv[s] <= dv_step(r_dv[s-1]);
                    r_dc[s] <= r_dc[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ook <= ~r_dc[DV_ST-1].zero;
            for (int i = 0; i < 3; i++) begin
                if (r_dc[DV_ST-1].zero) begin
                    r_ov[i] <= '0;
                end else if (r_dc[DV_ST-1].neg[i]) begin
                    r_ov[i] <= CW'(~r_dv[DV_ST-1].q[i] + QBP'(1));
                end else begin
                    r_ov[i] <= CW'(r_dv[DV_ST-1].q[i]);
                end
            end
        end
    end

    assign o_valid = r_v[NRM_ST-1];
    assign o_side  = r_sd[NRM_ST-1];
    assign o_vec   = r_ov;
    assign o_ok    = r_ook;

endmodule

// ===== hw/rtl/lav_cross.sv =====
module lav_cross import lav_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_evec i_a,
    input  t_uvec i_b,
    input  t_side i_side,
    output logic  o_valid,
    output t_wvec o_vec,
    output t_side o_side
);

    logic                  r_v1;
    logic                  r_v2;
    t_side                 r_s1;
    t_side                 r_s2;
    logic signed [PRW-1:0] r_p [6];
    t_wvec                 r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= i_side;
            r_s2   <= r_s1;
            r_p[0] <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1] <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2] <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3] <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4] <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5] <= $signed(i_a[1]) * $signed(i_b[0]);
            r_w[0] <= VW'(r_p[0]) - VW'(r_p[1]);
            r_w[1] <= VW'(r_p[2]) - VW'(r_p[3]);
            r_w[2] <= VW'(r_p[4]) - VW'(r_p[5]);
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_w;
    assign o_side  = r_s2;

endmodule

// ===== hw/rtl/lav_dot.sv =====
module lav_dot import lav_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_uvec i_v,
    input  t_side i_side,
    output logic  o_valid,
    output t_mat  o_mat
);

    function automatic logic [31:0] neg_round(input logic signed [DW-1:0] s);
        logic          pos;
        logic [DW-1:0] mag;
        logic [DW-1:0] rnd;
        pos = !s[DW-1] && (|s);
        mag = s[DW-1] ? (~s + DW'(1)) : s;
        rnd = (mag + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (pos) begin
            if (rnd > DW'(33'h080000000)) return 32'h80000000;
            return 32'(~rnd + DW'(1));
        end
        if (rnd > DW'(32'h7FFFFFFF)) return 32'h7FFFFFFF;
        return rnd[31:0];
    endfunction

    logic                  r_v [3];
    t_mat                  r_m [3];
    logic signed [PRW-1:0] r_p [3][3];
    logic signed [DW-1:0]  r_s [3];
    t_uvec                 w_ax [3];

    assign w_ax[0] = i_side.u;
    assign w_ax[1] = i_v;
    assign w_ax[2] = i_side.n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0].u  <= i_side.u;
            r_m[0].v  <= i_v;
            r_m[0].n  <= i_side.n;
            r_m[0].tr <= '0;
            r_m[0].ok <= i_side.ok;
            for (int a = 0; a < 3; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[a][c] <= $signed(w_ax[a][c]) * $signed(i_side.eye[c]);
                end
            end
            r_m[1] <= r_m[0];
            for (int a = 0; a < 3; a++) begin
                r_s[a] <= DW'(r_p[a][0]) + DW'(r_p[a][1]) + DW'(r_p[a][2]);
            end
            r_m[2].u  <= r_m[1].u;
            r_m[2].v  <= r_m[1].v;
            r_m[2].n  <= r_m[1].n;
            r_m[2].ok <= r_m[1].ok;
            for (int a = 0; a < 3; a++) r_m[2].tr[a] <= neg_round(r_s[a]);
        end
    end

    assign o_valid = r_v[2];
    assign o_mat   = r_m[2];

endmodule

// ===== hw/rtl/look_at_view_matrix_core.sv =====
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+----------------------------
// in       | i_in_valid  | o_in_ready  | i_in_req  (t_in_req)
// out      | o_out_valid | i_out_ready | o_out_req (t_out_req), 4 rows
//
// After a request is accepted, the first row is offered behind one input
// stage, three normalize pipes (20 stages each: magnitude, leading one, shift,
// scale, square, sum, 8 root stages, 5 divide stages, sign), two cross product
// pipes of 2 stages, a 3 stage dot/round pipe, then the row register.
// Sustained rate is set by the output row sequencer: four rows per request.
// Synchronous active low reset clears valid bits and the sequencer.
// An output stall freezes the pipeline once a result waits; nothing is dropped.
module look_at_view_matrix_core import lav_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    logic  w_adv;
    logic  w_take;

    logic  r_pv;
    t_wvec r_pd;
    t_side r_ps;

    logic  n1_v, n2_v, n3_v, c1_v, c2_v, d_v;
    t_uvec n1_vec, n2_vec, n3_vec;
    logic  n1_ok, n2_ok, n3_ok;
    t_side n1_sd, n2_sd, n3_sd, c1_sd, c2_sd;
    t_side s1, s2, s3;
    t_wvec c1_vec, c2_vec;
    t_evec w_na;
    t_mat  d_mat;

    logic       r_busy;
    logic [1:0] r_row;
    t_mat       r_mat;
    t_uvec      w_ax;

    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_adv) begin
            r_pv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pd[0] <= VW'(i_in_req.eye_x) - VW'(i_in_req.target_x);
            r_pd[1] <= VW'(i_in_req.eye_y) - VW'(i_in_req.target_y);
            r_pd[2] <= VW'(i_in_req.eye_z) - VW'(i_in_req.target_z);
            r_ps.eye <= {i_in_req.eye_z, i_in_req.eye_y, i_in_req.eye_x};
            r_ps.up  <= {i_in_req.upvec_z, i_in_req.upvec_y, i_in_req.upvec_x};
            r_ps.n   <= '0;
            r_ps.u   <= '0;
            r_ps.ok  <= 1'b1;
        end
    end

    lav_norm u_norm_n (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_valid(r_pv), .i_vec(r_pd), .i_side(r_ps),
        .o_valid(n1_v), .o_vec(n1_vec), .o_ok(n1_ok), .o_side(n1_sd)
    );

    always_comb begin
        s1    = n1_sd;
        s1.n  = n1_vec;
        s1.ok = n1_sd.ok & n1_ok;
    end

    lav_cross u_cross_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_valid(n1_v), .i_a(s1.up), .i_b(n1_vec), .i_side(s1),
        .o_valid(c1_v), .o_vec(c1_vec), .o_side(c1_sd)
    );

    lav_norm u_norm_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_valid(c1_v), .i_vec(c1_vec), .i_side(c1_sd),
        .o_valid(n2_v), .o_vec(n2_vec), .o_ok(n2_ok), .o_side(n2_sd)
    );

    always_comb begin
        s2    = n2_sd;
        s2.u  = n2_vec;
        s2.ok = n2_sd.ok & n2_ok;
        for (int i = 0; i < 3; i++) w_na[i] = 32'($signed(n2_sd.n[i]));
    end

    lav_cross u_cross_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_valid(n2_v), .i_a(w_na), .i_b(n2_vec), .i_side(s2),
        .o_valid(c2_v), .o_vec(c2_vec), .o_side(c2_sd)
    );

    lav_norm u_norm_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_valid(c2_v), .i_vec(c2_vec), .i_side(c2_sd),
        .o_valid(n3_v), .o_vec(n3_vec), .o_ok(n3_ok), .o_side(n3_sd)
    );

    always_comb begin
        s3    = n3_sd;
        s3.ok = n3_sd.ok & n3_ok;
    end

    lav_dot u_dot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
        .i_valid(n3_v), .i_v(n3_vec), .i_side(s3),
        .o_valid(d_v), .o_mat(d_mat)
    );

    // row sequencer
    assign w_take = !r_busy || (i_out_ready && r_row == 2'd3);
    assign w_adv  = !d_v || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 2'd0;
        end else if (w_take) begin
            r_busy <= d_v;
            r_row  <= 2'd0;
        end else if (i_out_ready) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && d_v) r_mat <= d_mat;
    end

    always_comb begin
        case (r_row)
            2'd0:    w_ax = r_mat.u;
            2'd1:    w_ax = r_mat.v;
            2'd2:    w_ax = r_mat.n;
            default: w_ax = '0;
        endcase
        o_out_req.row_index  = r_row;
        o_out_req.last_row   = (r_row == 2'd3);
        o_out_req.degenerate = !r_mat.ok;
        if (r_row == 2'd3) begin
            o_out_req.elem0 = '0;
            o_out_req.elem1 = '0;
            o_out_req.elem2 = '0;
            o_out_req.elem3 = 32'(1) << FRAC_BITS;
        end else if (!r_mat.ok) begin
            o_out_req.elem0 = '0;
            o_out_req.elem1 = '0;
            o_out_req.elem2 = '0;
            o_out_req.elem3 = '0;
        end else begin
            o_out_req.elem0 = 32'($signed(w_ax[0]));
            o_out_req.elem1 = 32'($signed(w_ax[1]));
            o_out_req.elem2 = 32'($signed(w_ax[2]));
            o_out_req.elem3 = r_mat.tr[r_row];
        end
    end

    assign o_out_valid = r_busy;

endmodule

// ===== hw/rtl/lav_chk.sv =====
module lav_chk import lav_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out_req
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("output request changed while stalled");

    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_req.last_row |=>
            o_out_valid && o_out_req.row_index == $past(o_out_req.row_index) + 2'd1)
        else $error("row sequence broken");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.last_row == (o_out_req.row_index == 2'd3))
        else $error("last_row mismatch");

    a_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.row_index == 2'd3 |->
            o_out_req.elem0 == 0 && o_out_req.elem1 == 0 && o_out_req.elem2 == 0 &&
            o_out_req.elem3 == (32'(1) << FRAC_BITS))
        else $error("bad homogeneous row");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.degenerate && o_out_req.row_index != 2'd3 |->
            o_out_req.elem0 == 0 && o_out_req.elem1 == 0 && o_out_req.elem2 == 0 &&
            o_out_req.elem3 == 0)
        else $error("degenerate row not zero");

endmodule

bind look_at_view_matrix_core lav_chk u_lav_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_req(o_out_req)
);
